>>> src/rfr_pkg.sv
package rfr_pkg;

   // Frame parser phases.
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SRC,
      PH_LEN,
      PH_PAY
   } phase_type;

   // Result kinds as they appear on the result channel.
   typedef enum logic [2:0] {
      KIND_FWD    = 3'd0,
      KIND_VALUE  = 3'd1,
      KIND_UNREC  = 3'd2,
      KIND_HDR_TO = 3'd3,
      KIND_PAY_TO = 3'd4
   } kind_type;

   // Register indexes on the configuration port (byte address is 4 * index).
   localparam logic [2:0] REG_OWN       = 3'd0;
   localparam logic [2:0] REG_HEARTBEAT = 3'd1;
   localparam logic [2:0] REG_CRYING    = 3'd2;
   localparam logic [2:0] REG_MOTOR     = 3'd3;
   localparam logic [2:0] REG_TIMEOUT   = 3'd4;

   // Payload opcodes recognized in a consumed frame.
   localparam logic [7:0] CHAR_H = 8'h48;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_R = 8'h52;

   // Depth of the command queue between parser and emitter.
   localparam int QueueDepth = 4;

   typedef struct packed {
      logic [7:0]  own;
      logic [7:0]  heartbeat;
      logic [7:0]  crying;
      logic [7:0]  motor;
      logic [15:0] timeout;
   } cfg_type;

   // One command expands to one result, or to three forwarded header bytes
   // when triple is set. The last flag applies to the final result only.
   typedef struct packed {
      kind_type   kind;
      logic       triple;
      logic [7:0] d0;
      logic [7:0] d1;
      logic [7:0] d2;
      logic       last;
   } cmd_type;

endpackage

>>> src/rfr_parser.sv
module rfr_parser
   import rfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   input  logic       in_action,
   input  logic [7:0] in_byte,
   output logic       in_stall,
   input  logic       q_full,
   output logic       push,
   output cmd_type    cmd
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  dest_ff, dest_in;
   logic [7:0]  src_ff, src_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  p0_ff, p0_in;
   logic [7:0]  p1_ff, p1_in;
   logic        passing_ff, passing_in;
   logic [15:0] ticks_ff, ticks_in;

   function automatic cmd_type evaluate(input logic [7:0] len, input logic [7:0] p0,
                                        input logic [7:0] p1, input logic [7:0] s,
                                        input cfg_type c);
      cmd_type r;
      logic    known;
      r      = '0;
      r.last = 1'b1;
      known  = (s == c.heartbeat) || (s == c.crying) || (s == c.motor);
      priority if (len >= 8'd2 && p0 == CHAR_H && s == c.heartbeat) begin
         r.kind = KIND_VALUE;
         r.d0   = p1;
      end else if (len >= 8'd2 && p0 == CHAR_C && s == c.crying) begin
         r.kind = KIND_VALUE;
         r.d0   = p1;
      end else if (len >= 8'd1 && p0 == CHAR_A && known) begin
         r.kind = KIND_VALUE;
         r.d0   = 8'd1;
      end else if (len >= 8'd2 && p0 == CHAR_R && known) begin
         r.kind = KIND_VALUE;
         r.d0   = p1;
      end else begin
         r.kind = KIND_UNREC;
      end
      return r;
   endfunction

   logic accept;
   assign in_stall = q_full;
   assign accept   = in_valid && !q_full;

   always_comb begin
      logic [16:0] ticks_plus;
      logic [7:0]  idx;
      logic [7:0]  left_next;
      logic [7:0]  p0_new;
      logic [7:0]  p1_new;
      phase_in   = phase_ff;
      dest_in    = dest_ff;
      src_in     = src_ff;
      len_in     = len_ff;
      left_in    = left_ff;
      p0_in      = p0_ff;
      p1_in      = p1_ff;
      passing_in = passing_ff;
      ticks_in   = ticks_ff;
      push       = 1'b0;
      cmd        = '0;
      ticks_plus = {1'b0, ticks_ff} + 17'd1;
      idx        = len_ff - left_ff;
      left_next  = left_ff - 8'd1;
      p0_new     = (idx == 8'd0) ? in_byte : p0_ff;
      p1_new     = (idx == 8'd1) ? in_byte : p1_ff;
      if (accept) begin
         if (in_action) begin
            if (phase_ff != PH_IDLE) begin
               if (ticks_plus >= {1'b0, cfg.timeout}) begin
                  push       = 1'b1;
                  cmd.kind   = (phase_ff == PH_PAY) ? KIND_PAY_TO : KIND_HDR_TO;
                  cmd.last   = 1'b1;
                  phase_in   = PH_IDLE;
                  ticks_in   = '0;
                  passing_in = 1'b0;
               end else begin
                  ticks_in = ticks_plus[15:0];
               end
            end
         end else begin
            ticks_in = '0;
            unique case (phase_ff)
               PH_IDLE: begin
                  dest_in    = in_byte;
                  p0_in      = '0;
                  p1_in      = '0;
                  passing_in = 1'b0;
                  phase_in   = PH_SRC;
               end
               PH_SRC: begin
                  src_in   = in_byte;
                  phase_in = PH_LEN;
               end
               PH_LEN: begin
                  len_in  = in_byte;
                  left_in = in_byte;
                  if (dest_ff != cfg.own) begin
                     push       = 1'b1;
                     cmd.kind   = KIND_FWD;
                     cmd.triple = 1'b1;
                     cmd.d0     = dest_ff;
                     cmd.d1     = src_ff;
                     cmd.d2     = in_byte;
                     cmd.last   = (in_byte == 8'd0);
                     passing_in = (in_byte != 8'd0);
                     phase_in   = (in_byte == 8'd0) ? PH_IDLE : PH_PAY;
                  end else begin
                     passing_in = 1'b0;
                     if (in_byte == 8'd0) begin
                        push     = 1'b1;
                        cmd      = evaluate(in_byte, p0_ff, p1_ff, src_ff, cfg);
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_PAY;
                     end
                  end
               end
               PH_PAY: begin
                  left_in = left_next;
                  if (passing_ff) begin
                     push     = 1'b1;
                     cmd.kind = KIND_FWD;
                     cmd.d0   = in_byte;
                     cmd.last = (left_next == 8'd0);
                     if (left_next == 8'd0) begin
                        phase_in   = PH_IDLE;
                        passing_in = 1'b0;
                     end
                  end else begin
                     p0_in = p0_new;
                     p1_in = p1_new;
                     if (left_next == 8'd0) begin
                        push     = 1'b1;
                        cmd      = evaluate(len_ff, p0_new, p1_new, src_ff, cfg);
                        phase_in = PH_IDLE;
                     end
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         dest_ff    <= '0;
         src_ff     <= '0;
         len_ff     <= '0;
         left_ff    <= '0;
         p0_ff      <= '0;
         p1_ff      <= '0;
         passing_ff <= 1'b0;
         ticks_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         dest_ff    <= dest_in;
         src_ff     <= src_in;
         len_ff     <= len_in;
         left_ff    <= left_in;
         p0_ff      <= p0_in;
         p1_ff      <= p1_in;
         passing_ff <= passing_in;
         ticks_ff   <= ticks_in;
      end
   end

endmodule

>>> src/rfr_cmd_queue.sv
module rfr_cmd_queue
   import rfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   localparam int PtrW   = $clog2(QueueDepth);
   localparam int CountW = $clog2(QueueDepth + 1);

   cmd_type           entries_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;

   assign head  = entries_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CountW'(QueueDepth));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/rfr_emitter.sv
module rfr_emitter
   import rfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head,
   input  logic       q_empty,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_stall,
   output logic [2:0] out_kind,
   output logic [7:0] out_data,
   output logic       out_last
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   kind_type   kind_ff, kind_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;

   logic out_free;
   logic emit;
   logic final_elem;

   assign out_free   = !valid_ff || !out_stall;
   assign emit       = out_free && !q_empty;
   assign final_elem = !head.triple || (idx_ff == 2'd2);
   assign pop        = emit && final_elem;

   always_comb begin
      kind_in  = kind_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      valid_in = out_free ? 1'b0 : valid_ff;
      if (emit) begin
         valid_in = 1'b1;
         kind_in  = head.kind;
         last_in  = final_elem ? head.last : 1'b0;
         unique case (idx_ff)
            2'd0:    data_in = head.d0;
            2'd1:    data_in = head.d1;
            default: data_in = head.d2;
         endcase
         idx_in = final_elem ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_data  = data_ff;
   assign out_last  = last_ff;

endmodule

>>> src/ring_frame_receiver.sv
// Ring frame receiver.
// The req channel carries one event per transaction: req_action 0 means a byte
// (req_rx_byte) arrived from the UART, req_action 1 means a 1 ms tick elapsed.
// The rsp channel carries results: forwarded bytes of frames for other nodes,
// the value or unrecognized verdict of frames for this node, and timeouts.
// Both channels use valid/stall; a transaction completes when valid is high
// and stall is low. The APB-style port writes five registers at 4 * index.
// Throughput: one req transaction per cycle while the queue is not full. A
// length byte of a passed-on frame yields three results, which drain one per
// cycle on rsp while rsp is not stalled; the command queue (four entries)
// between parser and emitter absorbs the difference. A command is written
// into the queue at the accepting edge and moves into the output register
// once it is at the head and that register is free; the other two forwarded
// header bytes follow it out of the same queue entry.
// Reset (synchronous) returns the parser to idle, empties the queue, drops
// rsp_valid and restores register defaults. While rsp is stalled the output
// register holds its result; the queue keeps filling and req_stall rises only
// once the queue is full.
module ring_frame_receiver
   import rfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input events
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   // Results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data,
   output logic        rsp_last,
   // Configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type cfg_ff, cfg_in;
   logic    cfg_write;
   logic [2:0] reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign cfg_write = psel && penable && pwrite && pready;

   // Register writes keep only the low bits of the written data; addresses
   // beyond the last register are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (reg_index)
            REG_OWN:       cfg_in.own       = pwdata[7:0];
            REG_HEARTBEAT: cfg_in.heartbeat = pwdata[7:0];
            REG_CRYING:    cfg_in.crying    = pwdata[7:0];
            REG_MOTOR:     cfg_in.motor     = pwdata[7:0];
            REG_TIMEOUT:   cfg_in.timeout   = pwdata[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_OWN:       prdata = {24'd0, cfg_ff.own};
         REG_HEARTBEAT: prdata = {24'd0, cfg_ff.heartbeat};
         REG_CRYING:    prdata = {24'd0, cfg_ff.crying};
         REG_MOTOR:     prdata = {24'd0, cfg_ff.motor};
         REG_TIMEOUT:   prdata = {16'd0, cfg_ff.timeout};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own       <= 8'd0;
         cfg_ff.heartbeat <= 8'd1;
         cfg_ff.crying    <= 8'd2;
         cfg_ff.motor     <= 8'd3;
         cfg_ff.timeout   <= 16'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: parses each event and turns it into at most one command.
   logic    q_full;
   logic    q_empty;
   logic    push;
   logic    pop;
   cmd_type push_cmd;
   cmd_type head;

   rfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_action (req_action),
      .in_byte   (req_rx_byte),
      .in_stall  (req_stall),
      .q_full    (q_full),
      .push      (push),
      .cmd       (push_cmd)
   );

   // Short queue that decouples the parser from the result channel.
   rfr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   // Back: expands each command into results in the output register.
   rfr_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_kind  (rsp_kind),
      .out_data  (rsp_data),
      .out_last  (rsp_last)
   );

endmodule

>>> tb/rfr_checker.sv
`timescale 1ns / 1ps

// Watches the event, result and register ports of the ring frame receiver,
// keeps its own copy of the parser state and registers, and compares every
// result transaction against the oldest predicted one.
module rfr_checker
   import rfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_kind,
   input  logic [7:0]  rsp_data,
   input  logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          mismatch_count,
   output int          results_outstanding
);

   typedef struct {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } result_type;

   result_type pending_results[$];

   cfg_type    regs;
   phase_type  phase;
   logic [7:0] dest_addr;
   logic [7:0] src_addr;
   logic [7:0] frame_len;
   logic [7:0] bytes_left;
   logic [7:0] pay0;
   logic [7:0] pay1;
   logic       passing;
   logic [15:0] silent_ticks;

   task automatic push_result(input kind_type k, input logic [7:0] d, input logic l);
      result_type r;
      r.kind = k;
      r.data = d;
      r.last = l;
      pending_results.push_back(r);
   endtask

   function automatic logic known_node(input logic [7:0] s);
      return s == regs.heartbeat || s == regs.crying || s == regs.motor;
   endfunction

   // Verdict on a consumed frame, taken in priority order.
   task automatic judge_frame();
      phase = PH_IDLE;
      if (frame_len >= 8'd2 && pay0 == CHAR_H && src_addr == regs.heartbeat)
         push_result(KIND_VALUE, pay1, 1'b1);
      else if (frame_len >= 8'd2 && pay0 == CHAR_C && src_addr == regs.crying)
         push_result(KIND_VALUE, pay1, 1'b1);
      else if (frame_len >= 8'd1 && pay0 == CHAR_A && known_node(src_addr))
         push_result(KIND_VALUE, 8'd1, 1'b1);
      else if (frame_len >= 8'd2 && pay0 == CHAR_R && known_node(src_addr))
         push_result(KIND_VALUE, pay1, 1'b1);
      else
         push_result(KIND_UNREC, 8'd0, 1'b1);
   endtask

   task automatic parse_event(input logic act, input logic [7:0] b);
      logic [16:0] ticks;
      logic [7:0]  idx;
      if (act) begin
         if (phase != PH_IDLE) begin
            ticks = {1'b0, silent_ticks} + 17'd1;
            if (ticks >= {1'b0, regs.timeout}) begin
               push_result((phase == PH_PAY) ? KIND_PAY_TO : KIND_HDR_TO, 8'd0, 1'b1);
               phase        = PH_IDLE;
               silent_ticks = '0;
               passing      = 1'b0;
            end else begin
               silent_ticks = ticks[15:0];
            end
         end
      end else begin
         silent_ticks = '0;
         case (phase)
            PH_IDLE: begin
               dest_addr = b;
               pay0      = '0;
               pay1      = '0;
               passing   = 1'b0;
               phase     = PH_SRC;
            end
            PH_SRC: begin
               src_addr = b;
               phase    = PH_LEN;
            end
            PH_LEN: begin
               frame_len  = b;
               bytes_left = b;
               if (dest_addr != regs.own) begin
                  passing = 1'b1;
                  push_result(KIND_FWD, dest_addr, 1'b0);
                  push_result(KIND_FWD, src_addr, 1'b0);
                  push_result(KIND_FWD, b, b == 8'd0);
                  if (b == 8'd0) begin
                     phase   = PH_IDLE;
                     passing = 1'b0;
                  end else begin
                     phase = PH_PAY;
                  end
               end else begin
                  passing = 1'b0;
                  if (b == 8'd0)
                     judge_frame();
                  else
                     phase = PH_PAY;
               end
            end
            default: begin
               idx        = frame_len - bytes_left;
               bytes_left = bytes_left - 8'd1;
               if (passing) begin
                  push_result(KIND_FWD, b, bytes_left == 8'd0);
                  if (bytes_left == 8'd0) begin
                     phase   = PH_IDLE;
                     passing = 1'b0;
                  end
               end else begin
                  if (idx == 8'd0)
                     pay0 = b;
                  else if (idx == 8'd1)
                     pay1 = b;
                  if (bytes_left == 8'd0)
                     judge_frame();
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      result_type exp;
      if (reset) begin
         regs.own       = 8'h00;
         regs.heartbeat = 8'h01;
         regs.crying    = 8'h02;
         regs.motor     = 8'h03;
         regs.timeout   = 16'd20;
         phase          = PH_IDLE;
         dest_addr      = '0;
         src_addr       = '0;
         frame_len      = '0;
         bytes_left     = '0;
         pay0           = '0;
         pay1           = '0;
         passing        = 1'b0;
         silent_ticks   = '0;
         pending_results.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, got kind %0d data %02h last %0b",
                        $time, rsp_kind, rsp_data, rsp_last);
            end else begin
               exp = pending_results.pop_front();
               if (rsp_kind !== exp.kind || rsp_data !== exp.data || rsp_last !== exp.last) begin
                  mismatch_count++;
                  $display("%0t: expected %0d/%02h/%0b, got %0d/%02h/%0b (kind/data/last)",
                           $time, exp.kind, exp.data, exp.last, rsp_kind, rsp_data, rsp_last);
               end
            end
         end
         if (psel === 1'b1 && penable === 1'b1 && pwrite === 1'b1 && pready === 1'b1) begin
            case (paddr[4:2])
               REG_OWN:       regs.own       = pwdata[7:0];
               REG_HEARTBEAT: regs.heartbeat = pwdata[7:0];
               REG_CRYING:    regs.crying    = pwdata[7:0];
               REG_MOTOR:     regs.motor     = pwdata[7:0];
               REG_TIMEOUT:   regs.timeout   = pwdata[15:0];
               default: ;
            endcase
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            parse_event(req_action, req_rx_byte);
      end
      results_outstanding = pending_results.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

// Top level of the ring frame receiver bench. It only makes stimulus and
// gives the verdict; the checker instance beside the block predicts every
// result and counts mismatches.
module testbench;
   import rfr_pkg::*;

   // A run that is still going after this many cycles is stuck somewhere.
   localparam int CycleLimit = 200000;

   // An address past the last register; writes to it must be ignored.
   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_data;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = 5'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   int          mismatch_count;
   int          results_outstanding;
   int          cycle_count = 0;

   // Sender bookkeeping: how many transactions remain in the current burst,
   // and how many transactions that the block acts on have gone out.
   int          burst_left = 0;
   int          items_sent = 0;

   // Copies of the register values last written, used only to shape the
   // random frames (the checker tracks the registers on its own).
   logic [7:0]  cur_own = 8'h00;
   logic [7:0]  cur_heartbeat = 8'h01;
   logic [7:0]  cur_crying = 8'h02;
   logic [7:0]  cur_motor = 8'h03;
   logic [15:0] cur_timeout = 16'd20;

   ring_frame_receiver i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_kind    (rsp_kind),
      .rsp_data    (rsp_data),
      .rsp_last    (rsp_last),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   rfr_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_data            (rsp_data),
      .rsp_last            (rsp_last),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .pready              (pready),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog. A correct run finishes far below this limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // The result side stalls on its own schedule. It switches between four
   // modes: never stalling, stalling at random, a fixed repeating pattern,
   // and long alternating runs of stall and no stall. Each mode lasts a
   // random number of cycles, so stalls fall on every phase of the block.
   int   stall_mode = 0;
   int   stall_left = 0;
   int   stall_tick = 0;
   int   run_left = 0;
   logic run_stall = 1'b0;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 35);
         2: rsp_stall <= (stall_tick % 3 == 0);
         default: begin
            if (run_left == 0) begin
               run_stall = ~run_stall;
               run_left  = $urandom_range(1, 12);
            end
            run_left--;
            rsp_stall <= run_stall;
         end
      endcase
   end

   // Sends one event transaction. The sender works in bursts: when a burst
   // is used up, valid drops for a random gap before the next burst begins.
   // Some bursts are long, which gives stretches without any idling.
   task automatic send_event(input logic act, input logic [7:0] b, input bit counts);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      burst_left--;
      if (counts)
         items_sent++;
   endtask

   // Holds the sender off until every predicted result has come out. Ticks
   // may still be in the pipeline without any result waiting, so the task
   // waits on past that point before anyone touches the registers.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_outstanding != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // One register write: a setup phase, then an access phase. pready is
   // always high, so the write lands at the edge ending the access phase.
   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Writes all five registers. The unused upper bits of each write carry
   // random junk, which the block has to drop.
   task automatic configure(input logic [7:0] own, input logic [7:0] hb,
                            input logic [7:0] cry, input logic [7:0] mot,
                            input logic [15:0] limit);
      logic [31:0] junk;
      junk = $urandom();
      write_reg(REG_OWN, {junk[31:8], own});
      junk = $urandom();
      write_reg(REG_HEARTBEAT, {junk[31:8], hb});
      junk = $urandom();
      write_reg(REG_CRYING, {junk[31:8], cry});
      junk = $urandom();
      write_reg(REG_MOTOR, {junk[31:8], mot});
      junk = $urandom();
      write_reg(REG_TIMEOUT, {junk[31:16], limit});
      cur_own       = own;
      cur_heartbeat = hb;
      cur_crying    = cry;
      cur_motor     = mot;
      cur_timeout   = limit;
   endtask

   // Sends one frame: destination, source, length, then the payload. The
   // first two payload bytes are given, the rest are random. Between bytes
   // a run of ticks may be inserted; once the run is long enough to reach
   // the timeout, the block drops the frame and so does this task.
   task automatic send_frame(input logic [7:0] dest, input logic [7:0] src,
                             input int len, input logic [7:0] p0, input logic [7:0] p1,
                             input int tick_pct);
      int          silent;
      int          run;
      logic [7:0]  b;
      silent = 0;
      for (int i = 0; i < len + 3; i++) begin
         if (i > 0 && $urandom_range(0, 99) < tick_pct) begin
            if ($urandom_range(0, 19) == 0 && cur_timeout <= 16'd64)
               run = cur_timeout;
            else
               run = $urandom_range(1, 6);
            if (run == 0)
               run = 1;
            for (int t = 0; t < run; t++) begin
               send_event(1'b1, 8'($urandom()), 1'b1);
               silent++;
               if (silent >= cur_timeout)
                  return;
            end
         end
         case (i)
            0:       b = dest;
            1:       b = src;
            2:       b = 8'(len);
            3:       b = p0;
            4:       b = p1;
            default: b = 8'($urandom());
         endcase
         send_event(1'b0, b, 1'b1);
         silent = 0;
      end
   endtask

   initial begin
      int          phase_start;
      int          len;
      logic [7:0]  dest;
      logic [7:0]  src;
      logic [7:0]  p0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // Directed part, with the reset register values (own address 0,
      // heartbeat 1, crying 2, motor 3, timeout 20).
      // A tick while idle must be ignored.
      send_event(1'b1, 8'hFF, 1'b0);
      // Heartbeat frame for this node: reports its second payload byte.
      send_frame(8'h00, 8'h01, 2, CHAR_H, 8'h5A, 0);
      // Frame for another node at the extremes of the byte range.
      send_frame(8'hFF, 8'h00, 1, 8'hFF, 8'h00, 0);
      // Zero length frame for this node is judged at once: unrecognized.
      send_frame(8'h00, 8'h03, 0, 8'h00, 8'h00, 0);
      // Zero length frame passed on: the length byte carries last.
      send_frame(8'h7F, 8'h80, 0, 8'h00, 8'h00, 0);
      // 'R' with only one payload byte is not enough.
      send_frame(8'h00, 8'h03, 1, CHAR_R, 8'h00, 0);
      wait_drained();

      // A timeout write with junk in its upper half keeps only the low 16
      // bits, and a write past the last register changes nothing.
      write_reg(REG_TIMEOUT, 32'h5A5A_0001);
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      cur_timeout = 16'd1;
      // Header timeout while waiting for the source byte.
      send_event(1'b0, 8'h10, 1'b1);
      send_event(1'b1, 8'h00, 1'b1);
      // Payload timeout on a frame that is being passed on.
      send_event(1'b0, 8'h10, 1'b1);
      send_event(1'b0, 8'h20, 1'b1);
      send_event(1'b0, 8'h02, 1'b1);
      send_event(1'b1, 8'hAA, 1'b1);
      wait_drained();

      // A zero timeout is out of range: the first tick inside a frame aborts.
      write_reg(REG_TIMEOUT, 32'h0000_0000);
      cur_timeout = 16'd0;
      send_event(1'b0, 8'h55, 1'b1);
      send_event(1'b1, 8'h00, 1'b1);

      // Random part, in phases with different register settings. Between
      // phases the sender waits for every result before reconfiguring.
      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         case (ph)
            0: configure(8'h00, 8'hFF, 8'hFF, 8'h00, 16'd1);
            1: configure(8'hFF, 8'h00, 8'h00, 8'hFF, 16'hFFFF);
            2: configure(8'($urandom()), 8'($urandom()), 8'($urandom()),
                         8'($urandom()), 16'd20);
            default: configure(8'($urandom()), 8'($urandom()), 8'($urandom()),
                               8'($urandom()), 16'($urandom_range(2, 8)));
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < 48) begin
            // Now and then some ticks while idle, which the block ignores.
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(1, 3)) send_event(1'b1, 8'($urandom()), 1'b0);
            // Rarely the sender waits until everything has come out.
            if ($urandom_range(0, 29) == 0)
               wait_drained();
            dest = ($urandom_range(0, 99) < 55) ? cur_own : 8'($urandom());
            case ($urandom_range(0, 4))
               0:       src = cur_heartbeat;
               1:       src = cur_crying;
               2:       src = cur_motor;
               3:       src = 8'($urandom());
               default: src = cur_heartbeat;
            endcase
            case ($urandom_range(0, 5))
               0:       p0 = CHAR_H;
               1:       p0 = CHAR_C;
               2:       p0 = CHAR_A;
               3:       p0 = CHAR_R;
               default: p0 = 8'($urandom());
            endcase
            case ($urandom_range(0, 19))
               0, 1:    len = 0;
               2, 3:    len = $urandom_range(5, 20);
               default: len = $urandom_range(1, 4);
            endcase
            send_frame(dest, src, len, p0, 8'($urandom()), 15);
         end
      end

      // Let everything drain, then keep the clock running so that any stray
      // result can show up before the verdict.
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
